// File: sv/assert_macros.svh
// ----------------------------------------------------------------------------
// Assertion macros
// Shared concurrent assertion forms, clocked on i_clk, quiet during reset.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication.
`define SST_ASSERT_NOW(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) \
        (ante) |-> (cons)) else $error(msg);

// Next-cycle implication.
`define SST_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) \
        (ante) |=> (cons)) else $error(msg);

`endif

// File: sv/sst_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Slot sequencer package
// Types and constants shared by the slot sequencer modules.
// ----------------------------------------------------------------------------
package sst_pkg;

    localparam int FN_MASK_W = 32;

    typedef enum logic [1:0] {
        OP_TICK       = 2'd0,
        OP_LOAD       = 2'd1,
        OP_CLEAR_SLOT = 2'd2,
        OP_CLEAR_ALL  = 2'd3
    } t_op;

    typedef enum logic [1:0] {
        KIND_DISPATCH = 2'd0,
        KIND_FINISH   = 2'd1,
        KIND_ACK      = 2'd2
    } t_kind;

    localparam logic CFG_SLOT_COUNT = 1'b0;
    localparam logic CFG_FN_MASK    = 1'b1;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_WALK,
        ST_EVAL,
        ST_FINISH,
        ST_WRITE
    } t_state;

    typedef struct packed {
        t_op         operation;
        logic [2:0]  slot_id;
        logic [31:0] start_index;
        logic [31:0] end_value;
        logic [31:0] step;
        logic [7:0]  fn_number;
        logic        run;
    } t_in_item;

    typedef struct packed {
        t_kind       kind;
        logic [2:0]  out_slot;
        logic [4:0]  out_fn;
        logic [31:0] cur_index;
        logic [31:0] after_end_count;
        logic        zero_torque;
        logic        last;
    } t_out_item;

    // One slot as stored in the slot memory.
    typedef struct packed {
        logic [31:0] index;
        logic [31:0] end_val;
        logic [31:0] step;
        logic [7:0]  fn;
        logic        active;
        logic [31:0] after_end;
    } t_slot_rec;

    // Evaluation of one slot for a tick.
    typedef struct packed {
        logic      present;
        logic      fn_err;
        t_slot_rec next_rec;
    } t_adv_res;

endpackage

// File: sv/sst_ram.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Generic RAM
// One write port, one read port, registered read data that holds without a read.
// ----------------------------------------------------------------------------
module sst_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 8
) (
    input  logic                                      i_clk,
    input  logic                                      i_we,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] i_waddr,
    input  logic [WIDTH-1:0]                          i_wdata,
    input  logic                                      i_re,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] i_raddr,
    output logic [WIDTH-1:0]                          o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

// File: sv/sst_adv.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Slot advance
// Checks a slot's function and computes its index and after-end count for a tick.
// ----------------------------------------------------------------------------
module sst_adv #(
    parameter int FN_TABLE_SIZE = 32
) (
    input  sst_pkg::t_slot_rec            i_rec,
    input  logic [sst_pkg::FN_MASK_W-1:0] i_fn_mask,
    output sst_pkg::t_adv_res             o_res
);

    logic [31:0] sum;

    always_comb begin
        sum = i_rec.index + i_rec.step;
        o_res.fn_err   = 32'(i_rec.fn) >= FN_TABLE_SIZE;
        o_res.present  = (i_rec.fn < 8'(sst_pkg::FN_MASK_W)) && i_fn_mask[i_rec.fn[4:0]];
        o_res.next_rec = i_rec;
        // Clamp at the end value and count the tick spent there.
        if (sum > i_rec.end_val) begin
            o_res.next_rec.index     = i_rec.end_val;
            o_res.next_rec.after_end = i_rec.after_end + 32'd1;
        end else begin
            o_res.next_rec.index = sum;
        end
    end

endmodule

// File: sv/slot_sequencer_table_top.sv
`timescale 1ns / 1ps
// Slot sequencer table: one item is handled at a time. A tick is accepted, walks
// the slots and then finishes; each slot is read from the slot memory, evaluated,
// and written back if active. The walk visits slot_count slots, or none when
// slot_count exceeds NUM_SLOTS. A bad function number ends the walk early at that
// slot. A load or clear is accepted, then applied in the write step. The slot
// memory's registered read data is why each visit has a read step followed by an
// evaluate step. A stalled output holds the walk at the next dispatch or at the
// closing result. Results leave through one output register, so a waiting result
// does not stop the next transaction from being accepted. Slot contents read as
// zero until a slot is loaded or advanced. Reset and clear-all only drop per-slot
// valid bits, so no clearing pass runs after reset.
// ----------------------------------------------------------------------------
// Slot sequencer table, top level
// Controller slot table stepped by tick operations, with dispatch results.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module slot_sequencer_table_top #(
    parameter int NUM_SLOTS     = 8,
    parameter int FN_TABLE_SIZE = 32
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    // input channel
    input  logic                i_in_valid,
    output logic                o_in_stall,
    input  sst_pkg::t_in_item   i_in_data,
    // output channel
    output logic                o_out_valid,
    input  logic                i_out_stall,
    output sst_pkg::t_out_item  o_out_data,
    // configuration write channel
    input  logic                i_cfg_valid,
    output logic                o_cfg_ready,
    input  logic                i_cfg_index,
    input  logic [31:0]         i_cfg_data
);

    localparam int SW = (NUM_SLOTS > 1) ? $clog2(NUM_SLOTS) : 1;
    localparam int CW = $clog2(NUM_SLOTS + 1);
    localparam int RW = $bits(sst_pkg::t_slot_rec);

    // State and control registers
    sst_pkg::t_state    r_state, n_state;
    sst_pkg::t_in_item  r_item, n_item;
    logic [CW-1:0]      r_slot, n_slot;
    logic [CW-1:0]      r_limit, n_limit;
    logic               r_err, n_err;
    logic               r_ran, n_ran;
    logic               r_rd_valid, n_rd_valid;
    logic [NUM_SLOTS-1:0] r_valid, n_valid;

    // Configuration registers
    logic [3:0]                   r_slot_count;
    logic [sst_pkg::FN_MASK_W-1:0] r_fn_mask;

    // Output register
    logic               r_out_valid, n_out_valid;
    sst_pkg::t_out_item r_out_data, n_out_data;

    // Memory and evaluation signals
    logic               ram_we;
    logic [SW-1:0]      ram_waddr;
    sst_pkg::t_slot_rec ram_wdata;
    logic               ram_re;
    logic [SW-1:0]      ram_raddr;
    logic [RW-1:0]      ram_rdata;
    sst_pkg::t_slot_rec cur_rec;
    sst_pkg::t_adv_res  adv;
    logic               out_free;
    logic               sid_ok;

    sst_ram #(
        .WIDTH (RW),
        .DEPTH (NUM_SLOTS)
    ) u_slot_ram (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (ram_waddr),
        .i_wdata (ram_wdata),
        .i_re    (ram_re),
        .i_raddr (ram_raddr),
        .o_rdata (ram_rdata)
    );

    // A slot never written since reset or clear reads as all zero.
    assign cur_rec = r_rd_valid ? sst_pkg::t_slot_rec'(ram_rdata) : '0;

    sst_adv #(
        .FN_TABLE_SIZE (FN_TABLE_SIZE)
    ) u_adv (
        .i_rec     (cur_rec),
        .i_fn_mask (r_fn_mask),
        .o_res     (adv)
    );

    // The output register can take a new result when empty or being drained.
    assign out_free    = !r_out_valid || !i_out_stall;
    assign o_in_stall  = (r_state != sst_pkg::ST_IDLE);
    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out_data;
    assign o_cfg_ready = 1'b1;
    assign sid_ok      = 32'(r_item.slot_id) < NUM_SLOTS;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state      <= sst_pkg::ST_IDLE;
            r_slot       <= '0;
            r_limit      <= '0;
            r_err        <= 1'b0;
            r_ran        <= 1'b0;
            r_rd_valid   <= 1'b0;
            r_valid      <= '0;
            r_out_valid  <= 1'b0;
            r_slot_count <= '0;
            r_fn_mask    <= '0;
        end else begin
            r_state     <= n_state;
            r_slot      <= n_slot;
            r_limit     <= n_limit;
            r_err       <= n_err;
            r_ran       <= n_ran;
            r_rd_valid  <= n_rd_valid;
            r_valid     <= n_valid;
            r_out_valid <= n_out_valid;
            // User sends configuration writes only while block is idle; unchecked.
            if (i_cfg_valid && o_cfg_ready) begin
                case (i_cfg_index)
                    sst_pkg::CFG_SLOT_COUNT: r_slot_count <= i_cfg_data[3:0];
                    sst_pkg::CFG_FN_MASK:    r_fn_mask    <= i_cfg_data;
                    default: ;
                endcase
            end
        end
    end

    // Payload registers carry no reset.
    always_ff @(posedge i_clk) begin
        r_item     <= n_item;
        r_out_data <= n_out_data;
    end

    always_comb begin
        n_state     = r_state;
        n_item      = r_item;
        n_slot      = r_slot;
        n_limit     = r_limit;
        n_err       = r_err;
        n_ran       = r_ran;
        n_rd_valid  = r_rd_valid;
        n_valid     = r_valid;
        n_out_valid = r_out_valid && i_out_stall;
        n_out_data  = r_out_data;
        ram_we      = 1'b0;
        ram_waddr   = r_slot[SW-1:0];
        ram_wdata   = adv.next_rec;
        ram_re      = 1'b0;
        ram_raddr   = r_slot[SW-1:0];

        case (r_state)
            sst_pkg::ST_IDLE: begin
                if (i_in_valid) begin
                    n_item = i_in_data;
                    if (i_in_data.operation == sst_pkg::OP_TICK) begin
                        // Start the walk; a count beyond the table visits nothing.
                        n_slot  = '0;
                        n_limit = (32'(r_slot_count) > NUM_SLOTS) ? '0 : CW'(r_slot_count);
                        n_err   = 1'b0;
                        n_ran   = 1'b0;
                        n_state = sst_pkg::ST_WALK;
                    end else begin
                        n_state = sst_pkg::ST_WRITE;
                    end
                end
            end

            sst_pkg::ST_WALK: begin
                // Issue the read of the next slot, or close the tick.
                if (r_slot < r_limit) begin
                    ram_re     = 1'b1;
                    n_rd_valid = r_valid[r_slot[SW-1:0]];
                    n_state    = sst_pkg::ST_EVAL;
                end else begin
                    n_state = sst_pkg::ST_FINISH;
                end
            end

            sst_pkg::ST_EVAL: begin
                if (!cur_rec.active) begin
                    n_slot  = r_slot + CW'(1);
                    n_state = sst_pkg::ST_WALK;
                end else if (adv.fn_err) begin
                    // Bad function number: stop the walk, leave later slots alone.
                    n_err   = 1'b1;
                    n_state = sst_pkg::ST_FINISH;
                end else if (!adv.present || out_free) begin
                    // Write back the advance; emit a dispatch when the function exists.
                    ram_we  = 1'b1;
                    n_valid[r_slot[SW-1:0]] = 1'b1;
                    if (adv.present) begin
                        n_ran       = 1'b1;
                        n_out_valid = 1'b1;
                        n_out_data  = '0;
                        n_out_data.kind            = sst_pkg::KIND_DISPATCH;
                        n_out_data.out_slot        = 3'(r_slot);
                        n_out_data.out_fn          = cur_rec.fn[4:0];
                        n_out_data.cur_index       = cur_rec.index;
                        n_out_data.after_end_count = cur_rec.after_end;
                    end
                    n_slot  = r_slot + CW'(1);
                    n_state = sst_pkg::ST_WALK;
                end
            end

            sst_pkg::ST_FINISH: begin
                if (out_free) begin
                    n_out_valid = 1'b1;
                    n_out_data  = '0;
                    n_out_data.kind        = sst_pkg::KIND_FINISH;
                    n_out_data.zero_torque = r_err || !r_ran;
                    n_out_data.last        = 1'b1;
                    n_state = sst_pkg::ST_IDLE;
                end
            end

            sst_pkg::ST_WRITE: begin
                if (out_free) begin
                    ram_waddr           = SW'(r_item.slot_id);
                    ram_wdata           = '0;
                    ram_wdata.index     = r_item.start_index;
                    ram_wdata.end_val   = r_item.end_value;
                    ram_wdata.step      = r_item.step;
                    ram_wdata.fn        = r_item.fn_number;
                    ram_wdata.active    = r_item.run;
                    case (r_item.operation)
                        sst_pkg::OP_LOAD: begin
                            if (sid_ok) begin
                                ram_we = 1'b1;
                                n_valid[SW'(r_item.slot_id)] = 1'b1;
                            end
                        end
                        sst_pkg::OP_CLEAR_SLOT: begin
                            if (sid_ok) begin
                                n_valid[SW'(r_item.slot_id)] = 1'b0;
                            end
                        end
                        sst_pkg::OP_CLEAR_ALL: begin
                            n_valid = '0;
                        end
                        default: ;
                    endcase
                    // Acknowledge the write, whether or not the slot exists.
                    n_out_valid = 1'b1;
                    n_out_data  = '0;
                    n_out_data.kind = sst_pkg::KIND_ACK;
                    n_out_data.last = 1'b1;
                    n_state = sst_pkg::ST_IDLE;
                end
            end

            default: begin
                n_state = sst_pkg::ST_IDLE;
            end
        endcase
    end

    // Only the closing result of a transaction carries last.
    `SST_ASSERT_NOW(a_last_kind, o_out_valid, (o_out_data.last == (o_out_data.kind != sst_pkg::KIND_DISPATCH)), "last flag does not match result kind")
    // A slot is evaluated only inside the visit range.
    `SST_ASSERT_NOW(a_eval_range, (r_state == sst_pkg::ST_EVAL), (r_slot < r_limit), "slot evaluated beyond the visit range")
    // A read is always followed by its evaluation.
    `SST_ASSERT_NEXT(a_read_eval, ram_re, (r_state == sst_pkg::ST_EVAL), "slot read without evaluation")
    // A finished tick or write always hands over a closing result.
    `SST_ASSERT_NEXT(a_close_emit, ((r_state == sst_pkg::ST_FINISH || r_state == sst_pkg::ST_WRITE) && out_free), (o_out_valid && o_out_data.last), "transaction closed without a final result")

endmodule
